// ----- src/infix_to_postfix_converter_macros.svh -----
// Assertion macros shared by the infix to postfix converter checker.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge out of reset
`define ITP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp check failed");

// Next-cycle implication, checked at each rising clock edge out of reset
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itp check failed");

`endif

// ----- src/itp_pkg.sv -----
// Shared types, character codes and decode functions for the infix to postfix converter.
package itp_pkg;

    // Character codes
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Precedence ranks
    localparam logic [1:0] RANK_NONE = 2'd0;
    localparam logic [1:0] RANK_ADD  = 2'd1;
    localparam logic [1:0] RANK_MUL  = 2'd2;

    typedef enum logic [2:0] {
        K_SPACE,
        K_OPEN,
        K_CLOSE,
        K_OPERAND,
        K_OPERATOR
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERFLOW,
        ST_UNMATCHED
    } t_status;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_CHAR,
        EMIT_TOP,
        EMIT_TERM
    } t_emit;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SETTLE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    latch;
        logic    push;
        logic    pop;
        logic    clr;
        t_emit   emit;
        t_status set_err;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic  is_end;
        t_kind kind;
        logic  sp_zero;
        logic  full;
        logic  top_open;
        logic  top_outranks;
        logic  out_free;
    } t_stat;

    function automatic logic [1:0] char_rank(input logic [7:0] ch);
        logic [1:0] r;
        r = RANK_NONE;
        if (ch == CH_MUL || ch == CH_DIV) r = RANK_MUL;
        else if (ch == CH_ADD || ch == CH_SUB) r = RANK_ADD;
        return r;
    endfunction

    function automatic t_kind char_kind(input logic [7:0] ch);
        t_kind k;
        if (ch == CH_SPACE) k = K_SPACE;
        else if (ch == CH_OPEN) k = K_OPEN;
        else if (ch == CH_CLOSE) k = K_CLOSE;
        else if (char_rank(ch) != RANK_NONE) k = K_OPERATOR;
        else k = K_OPERAND;
        return k;
    endfunction

endpackage

// ----- src/itp_datapath.sv -----
// Datapath: input latch, operator stack memory, stack pointer, sticky status and output register.
module itp_datapath import itp_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_in_char,
    input  logic       i_in_end,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_out_end,
    output logic [1:0] o_out_status
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    logic [7:0]     r_mem [STACK_DEPTH];
    logic [7:0]     r_rd;
    logic [7:0]     r_char;
    logic           r_end;
    logic [SPW-1:0] r_sp;
    logic [SPW-1:0] n_sp;
    logic [SPW-1:0] w_sp_dec;
    t_status        r_err;
    t_status        n_err;
    logic           r_ovalid;
    logic           n_ovalid;
    logic [7:0]     r_ochar;
    logic           r_oend;
    t_status        r_ostat;
    logic           w_out_free;

    assign w_sp_dec   = r_sp - SPW'(1);
    assign w_out_free = !r_ovalid || i_out_ready;

    // Stack memory: push writes at the pointer, top entry is read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_sp[AW-1:0]] <= r_char;
        end
        r_rd <= r_mem[w_sp_dec[AW-1:0]];
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_char <= i_in_char;
            r_end  <= i_in_end;
        end
    end

    // Next pointer, sticky status and output valid
    always_comb begin
        n_sp = r_sp;
        if (i_cmd.clr) n_sp = '0;
        else if (i_cmd.push) n_sp = r_sp + SPW'(1);
        else if (i_cmd.pop) n_sp = w_sp_dec;

        n_err = r_err;
        if (i_cmd.clr) n_err = ST_OK;
        else if (r_err == ST_OK) n_err = i_cmd.set_err;

        n_ovalid = r_ovalid && !i_out_ready;
        if (i_cmd.emit != EMIT_NONE) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_sp     <= n_sp;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EMIT_CHAR: begin
                r_ochar <= r_char;
                r_oend  <= 1'b0;
                r_ostat <= ST_OK;
            end
            EMIT_TOP: begin
                r_ochar <= r_rd;
                r_oend  <= 1'b0;
                r_ostat <= ST_OK;
            end
            EMIT_TERM: begin
                r_ochar <= 8'h00;
                r_oend  <= 1'b1;
                r_ostat <= r_err;
            end
            default: begin
            end
        endcase
    end

    // Report status to the controller
    always_comb begin
        o_stat.is_end       = r_end;
        o_stat.kind         = char_kind(r_char);
        o_stat.sp_zero      = (r_sp == '0);
        o_stat.full         = (r_sp == SPW'(STACK_DEPTH));
        o_stat.top_open     = (r_rd == CH_OPEN);
        o_stat.top_outranks = (char_rank(r_char) <= char_rank(r_rd));
        o_stat.out_free     = w_out_free;
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_char   = r_ochar;
    assign o_out_end    = r_oend;
    assign o_out_status = r_ostat;

endmodule

// ----- src/itp_ctrl.sv -----
// Controller: state machine that sequences pushes, pops and emits per item.
module itp_ctrl import itp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.is_end) begin
                    if (!i_stat.sp_zero) begin
                        if (i_stat.out_free) n_state = S_SETTLE;
                    end else if (i_stat.out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    case (i_stat.kind)
                        K_CLOSE: begin
                            if (i_stat.sp_zero || i_stat.top_open) n_state = S_IDLE;
                            else if (i_stat.out_free) n_state = S_SETTLE;
                        end
                        K_OPERAND: begin
                            if (i_stat.out_free) n_state = S_IDLE;
                        end
                        K_OPERATOR: begin
                            if (i_stat.sp_zero || !i_stat.top_outranks) n_state = S_IDLE;
                            else if (i_stat.out_free) n_state = S_SETTLE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SETTLE: n_state = S_DECODE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.latch   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.push    = 1'b0;
        o_cmd.pop     = 1'b0;
        o_cmd.clr     = 1'b0;
        o_cmd.emit    = EMIT_NONE;
        o_cmd.set_err = ST_OK;
        if (r_state == S_DECODE) begin
            if (i_stat.is_end) begin
                // flush one entry, then terminate and clear
                if (i_stat.out_free) begin
                    if (!i_stat.sp_zero) begin
                        o_cmd.pop  = 1'b1;
                        o_cmd.emit = EMIT_TOP;
                    end else begin
                        o_cmd.emit = EMIT_TERM;
                        o_cmd.clr  = 1'b1;
                    end
                end
            end else begin
                case (i_stat.kind)
                    K_OPEN: begin
                        if (i_stat.full) o_cmd.set_err = ST_OVERFLOW;
                        else o_cmd.push = 1'b1;
                    end
                    K_CLOSE: begin
                        if (i_stat.sp_zero) begin
                            o_cmd.set_err = ST_UNMATCHED;
                        end else if (i_stat.top_open) begin
                            o_cmd.pop = 1'b1;
                        end else if (i_stat.out_free) begin
                            o_cmd.pop  = 1'b1;
                            o_cmd.emit = EMIT_TOP;
                        end
                    end
                    K_OPERAND: begin
                        if (i_stat.out_free) o_cmd.emit = EMIT_CHAR;
                    end
                    K_OPERATOR: begin
                        if (!i_stat.sp_zero && i_stat.top_outranks) begin
                            if (i_stat.out_free) begin
                                o_cmd.pop  = 1'b1;
                                o_cmd.emit = EMIT_TOP;
                            end
                        end else if (i_stat.full) begin
                            o_cmd.set_err = ST_OVERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- src/infix_to_postfix_converter.sv -----
// Sequencing: the first result of an item is loaded into the output register from the decode
// state that follows its acceptance; each further result passes through a settle state, which
// lets the registered stack read catch up, and another decode, and waits while the output is
// stalled. A new item is taken only from idle; the matching open is dropped in the last decode with no settle.
// Reset: synchronous, active low; clears the stack pointer, sticky status, state and
// output valid. Stack contents are not cleared; entries above the pointer are never used.
module infix_to_postfix_converter import itp_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,   // end_of_expression
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast,   // is_end
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_char    (s_axis_tdata),
        .i_in_end     (s_axis_tlast),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_char   (m_axis_tdata),
        .o_out_end    (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

endmodule

// ----- src/itp_checker.sv -----
// Port-level checks for the infix to postfix converter, bound to the top level.
`include "infix_to_postfix_converter_macros.svh"
module itp_port_checks (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);

    // stalled result holds
    `ITP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // character items carry a clean status
    `ITP_ASSERT_NOW(a_char_status, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == 2'd0)
    // terminator carries a zero character
    `ITP_ASSERT_NOW(a_term_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata == 8'h00)
    // no undefined status code
    `ITP_ASSERT_NOW(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser != 2'd3)
    // an accepted item is decoded before the next one is taken
    `ITP_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind infix_to_postfix_converter itp_port_checks u_itp_checker (.*);
